### src/assert_macros.svh
// Assertion macros used by the RTL of the history table core.
// Depends on nothing; each macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock, held off while rst is high.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/mkht_pkg.sv
// Types and constants of the keyed history table.
// No dependencies; used by mru_keyed_history_table_core and its testbench.
`default_nettype none

package mkht_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [7:0] URGENT_LEVEL = 8'd2;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_DISMISS = 3'd1,
    OP_INVOKE  = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_BIND    = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] key;
    logic [20:0] icon;
    logic [7:0]  urgency;
    logic [31:0] handle;
    logic        action;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FRONT,
    S_REMOVE,
    S_BIND_RD,
    S_BIND_CHK,
    S_READ_RD,
    S_READ_CAP,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

### src/mkht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mkht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/mru_keyed_history_table_core.sv
// Keyed history table, newest entry first, with move to front on key match.
// Depends on mkht_pkg, mkht_ram and assert_macros.svh.
//
// Requests enter on in_valid/in_ready; one result per request leaves on
// out_valid/out_ready. in_ready is high only while the sequencer is idle.
// Entries live in one RAM with a registered read port, and a single 32-bit
// comparator scans keys or ids one entry visited at a time. Per operation:
//   clear, unused codes, read out of range, non-push on an empty table:
//     straight to the result
//   read by index, bind: one RAM read
//   push: key scan (skipped for key 0 or an empty table), then shift and front write
//   dismiss, invoke: id scan, then gap close on a hit
// A new request is accepted in the cycle after the previous result is loaded.
// A finished result sits in the output register; the next request is
// accepted while it waits, and its own result holds in the sequencer
// until the register is free, so a stalled receiver loses nothing.
// Reset (rst, synchronous) empties the table and zeroes the serial and
// revision counters; no clearing pass is needed since only filled
// positions are ever read.
`default_nettype none
`include "assert_macros.svh"

module mru_keyed_history_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] key_rid,
  input  wire logic [31:0] entry_id,
  input  wire logic [3:0]  entry_index,
  input  wire logic [20:0] icon_code,
  input  wire logic [7:0]  urgency_in,
  input  wire logic [31:0] payload_handle,
  input  wire logic        action_present,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      result_id,
  output logic [31:0]      result_key,
  output logic [20:0]      result_icon,
  output logic [7:0]       result_urgency,
  output logic             urgent_flag,
  output logic [31:0]      result_handle,
  output logic             result_action,
  output logic             action_fired,
  output logic [4:0]       entry_count,
  output logic [31:0]      revision
);

  localparam int CNT_W  = mkht_pkg::CNT_W;
  localparam int ADDR_W = mkht_pkg::ADDR_W;

  mkht_pkg::state_t state, state_next;

  // Latched request
  logic [2:0]  op;
  logic [31:0] key;
  logic [31:0] eid;
  logic [3:0]  idx;
  logic [20:0] icon;
  logic [7:0]  urg;
  logic [31:0] hnd;
  logic        act;

  logic [CNT_W-1:0] fill;
  logic [31:0]      serial;
  logic [31:0]      change;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] j;

  // Working result
  logic [1:0]  w_status;
  logic [31:0] w_id;
  logic [31:0] w_key;
  logic [20:0] w_icon;
  logic [7:0]  w_urg;
  logic [31:0] w_handle;
  logic        w_action;
  logic        w_fired;

  // RAM port
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  mkht_pkg::entry_t    wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  mkht_pkg::entry_t    rd_data;

  mkht_ram #(
    .WIDTH(mkht_pkg::ENTRY_W),
    .DEPTH(mkht_pkg::CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Shared comparator: key for push, id for dismiss and invoke
  logic        scan_key;
  logic [31:0] scan_target;
  logic        cmp_hit;

  assign scan_key    = (op == mkht_pkg::OP_PUSH);
  assign scan_target = scan_key ? key : eid;
  assign cmp_hit     = ((scan_key ? rd_data.key : rd_data.id) == scan_target);

  logic             table_full;
  logic [CNT_W-1:0] miss_pos;
  logic [CNT_W-1:0] miss_fill;
  logic [CNT_W:0]   cnt_inc_w;
  logic [CNT_W:0]   j_inc2_w;
  logic [CNT_W-1:0] j_dec;
  logic [CNT_W-1:0] j_inc;
  logic             scan_last;
  logic             idx_ok;
  logic             do_load;

  assign table_full = (fill >= CNT_W'(mkht_pkg::CAPACITY));
  assign miss_pos   = table_full ? CNT_W'(mkht_pkg::CAPACITY - 1) : fill;
  assign miss_fill  = table_full ? fill : fill + CNT_W'(1);
  assign cnt_inc_w  = (CNT_W + 1)'(cnt) + (CNT_W + 1)'(1);
  assign j_inc2_w   = (CNT_W + 1)'(j) + (CNT_W + 1)'(2);
  assign j_dec      = j - CNT_W'(1);
  assign j_inc      = j + CNT_W'(1);
  assign scan_last  = (cnt_inc_w >= (CNT_W + 1)'(fill));
  assign idx_ok     = (8'(entry_index) < 8'(fill));
  assign do_load    = (state == mkht_pkg::S_FINISH) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mkht_pkg::S_IDLE: begin
        if (in_valid) state_next = mkht_pkg::S_DISPATCH;
      end
      mkht_pkg::S_DISPATCH: begin
        unique case (op)
          mkht_pkg::OP_PUSH: begin
            if (key != 32'd0 && fill != '0) state_next = mkht_pkg::S_SCAN_RD;
            else if (miss_pos == '0)        state_next = mkht_pkg::S_FRONT;
            else                            state_next = mkht_pkg::S_SHIFT_RD;
          end
          mkht_pkg::OP_DISMISS, mkht_pkg::OP_INVOKE: begin
            state_next = (fill == '0) ? mkht_pkg::S_FINISH : mkht_pkg::S_SCAN_RD;
          end
          mkht_pkg::OP_BIND: begin
            state_next = (fill == '0) ? mkht_pkg::S_FINISH : mkht_pkg::S_BIND_RD;
          end
          mkht_pkg::OP_READ: begin
            state_next = (8'(idx) < 8'(fill)) ? mkht_pkg::S_READ_RD : mkht_pkg::S_FINISH;
          end
          default: state_next = mkht_pkg::S_FINISH;
        endcase
      end
      mkht_pkg::S_SCAN_RD: state_next = mkht_pkg::S_SCAN_CMP;
      mkht_pkg::S_SCAN_CMP: begin
        if (cmp_hit) begin
          if (scan_key)
            state_next = (cnt == '0) ? mkht_pkg::S_FRONT : mkht_pkg::S_SHIFT_RD;
          else
            state_next = scan_last ? mkht_pkg::S_REMOVE : mkht_pkg::S_SHIFT_RD;
        end else if (scan_last) begin
          // a push miss on a non-empty table always needs a shift; other misses finish
          state_next = scan_key ? mkht_pkg::S_SHIFT_RD : mkht_pkg::S_FINISH;
        end else begin
          state_next = mkht_pkg::S_SCAN_RD;
        end
      end
      mkht_pkg::S_SHIFT_RD: state_next = mkht_pkg::S_SHIFT_WR;
      mkht_pkg::S_SHIFT_WR: begin
        if (scan_key)
          state_next = (j == CNT_W'(1)) ? mkht_pkg::S_FRONT : mkht_pkg::S_SHIFT_RD;
        else
          state_next = (j_inc2_w >= (CNT_W + 1)'(fill)) ? mkht_pkg::S_REMOVE
                                                         : mkht_pkg::S_SHIFT_RD;
      end
      mkht_pkg::S_FRONT:    state_next = mkht_pkg::S_FINISH;
      mkht_pkg::S_REMOVE:   state_next = mkht_pkg::S_FINISH;
      mkht_pkg::S_BIND_RD:  state_next = mkht_pkg::S_BIND_CHK;
      mkht_pkg::S_BIND_CHK: state_next = mkht_pkg::S_FINISH;
      mkht_pkg::S_READ_RD:  state_next = mkht_pkg::S_READ_CAP;
      mkht_pkg::S_READ_CAP: state_next = mkht_pkg::S_FINISH;
      mkht_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = mkht_pkg::S_IDLE;
      end
      default: state_next = mkht_pkg::S_IDLE;
    endcase
  end

  // RAM control and handshake
  always_comb begin
    in_ready = (state == mkht_pkg::S_IDLE);
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = rd_data;
    unique case (state)
      mkht_pkg::S_SCAN_RD:  rd_addr = cnt[ADDR_W-1:0];
      mkht_pkg::S_SHIFT_RD: rd_addr = scan_key ? j_dec[ADDR_W-1:0] : j_inc[ADDR_W-1:0];
      mkht_pkg::S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = j[ADDR_W-1:0];
      end
      mkht_pkg::S_FRONT: begin
        wr_en           = 1'b1;
        wr_data.id      = w_id;
        wr_data.key     = key;
        wr_data.icon    = icon;
        wr_data.urgency = urg;
        wr_data.handle  = hnd;
        wr_data.action  = act;
      end
      mkht_pkg::S_BIND_CHK: begin
        wr_en       = (rd_data.key == 32'd0);
        wr_data.key = key;
      end
      mkht_pkg::S_READ_RD: rd_addr = idx[ADDR_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mkht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      serial <= 32'd0;
      change <= 32'd0;
    end else begin
      unique case (state)
        mkht_pkg::S_DISPATCH: begin
          if (op == mkht_pkg::OP_CLEAR) begin
            fill   <= '0;
            change <= change + 32'd1;
          end else if (op == mkht_pkg::OP_PUSH && (key == 32'd0 || fill == '0)) begin
            fill   <= miss_fill;
            serial <= serial + 32'd1;
          end
        end
        mkht_pkg::S_SCAN_CMP: begin
          if (scan_key && !cmp_hit && scan_last) begin
            fill   <= miss_fill;
            serial <= serial + 32'd1;
          end
        end
        mkht_pkg::S_FRONT:  change <= change + 32'd1;
        mkht_pkg::S_REMOVE: begin
          fill   <= fill - CNT_W'(1);
          change <= change + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // Request latch, scan position and working result
  always_ff @(posedge clk) begin
    unique case (state)
      mkht_pkg::S_IDLE: begin
        if (in_valid) begin
          op       <= operation;
          key      <= key_rid;
          eid      <= entry_id;
          idx      <= entry_index;
          icon     <= icon_code;
          urg      <= urgency_in;
          hnd      <= payload_handle;
          act      <= action_present;
          cnt      <= '0;
          w_id     <= 32'd0;
          w_key    <= 32'd0;
          w_icon   <= 21'd0;
          w_urg    <= 8'd0;
          w_handle <= 32'd0;
          w_action <= 1'b0;
          w_fired  <= 1'b0;
          if (operation == mkht_pkg::OP_READ && !idx_ok) begin
            w_status <= mkht_pkg::ST_RANGE;
          end else if ((operation == mkht_pkg::OP_DISMISS ||
                        operation == mkht_pkg::OP_INVOKE) && fill == '0) begin
            w_status <= mkht_pkg::ST_NOT_FOUND;
          end else begin
            w_status <= mkht_pkg::ST_OK;
          end
        end
      end
      mkht_pkg::S_DISPATCH: begin
        if (op == mkht_pkg::OP_PUSH && (key == 32'd0 || fill == '0)) begin
          j    <= miss_pos;
          w_id <= serial + 32'd1;
        end
      end
      mkht_pkg::S_SCAN_CMP: begin
        if (cmp_hit) begin
          j <= cnt;
          if (scan_key) w_id <= rd_data.id;
          if (op == mkht_pkg::OP_INVOKE) begin
            w_key   <= rd_data.key;
            w_fired <= (rd_data.key != 32'd0) && rd_data.action;
          end
        end else if (scan_last) begin
          if (scan_key) begin
            j    <= miss_pos;
            w_id <= serial + 32'd1;
          end else begin
            w_status <= mkht_pkg::ST_NOT_FOUND;
          end
        end else begin
          cnt <= cnt_inc_w[CNT_W-1:0];
        end
      end
      mkht_pkg::S_SHIFT_WR: j <= scan_key ? j_dec : j_inc;
      mkht_pkg::S_READ_CAP: begin
        w_id     <= rd_data.id;
        w_key    <= rd_data.key;
        w_icon   <= rd_data.icon;
        w_urg    <= rd_data.urgency;
        w_handle <= rd_data.handle;
        w_action <= rd_data.action;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      status         <= w_status;
      result_id      <= w_id;
      result_key     <= w_key;
      result_icon    <= w_icon;
      result_urgency <= w_urg;
      urgent_flag    <= (w_urg >= mkht_pkg::URGENT_LEVEL);
      result_handle  <= w_handle;
      result_action  <= w_action;
      action_fired   <= w_fired;
      entry_count    <= 5'(fill);
      revision       <= change;
    end
  end

  `ASSERT_CLK_RST(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready,
                  "request accepted while sequencer busy")
  `ASSERT_CLK_RST(a_hold_result, (state == mkht_pkg::S_FINISH && out_valid && !out_ready)
                  |=> (state == mkht_pkg::S_FINISH), "result overwrote a stalled output")
  `ASSERT_CLK_RST(a_write_in_range, wr_en |-> (8'(wr_addr) < 8'(fill)),
                  "RAM write beyond filled entries")
  `ASSERT_CLK(a_fill_bound, rst || (fill <= CNT_W'(mkht_pkg::CAPACITY)),
              "fill count above capacity")

endmodule

`default_nettype wire

### sim/mru_keyed_history_table_core_tb.sv
// Self-checking testbench for mru_keyed_history_table_core, the newest-first keyed table.
// Depends on mkht_pkg and the core RTL; a built-in predictor checks every result.
`timescale 1ns / 100ps

module mru_keyed_history_table_core_tb;
  import mkht_pkg::*;

  localparam logic [2:0]  OP_SPARE_LO   = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
  localparam logic [20:0] ICON_MAX      = 21'd1114111;
  localparam logic [31:0] KEY_POOL_BASE = 32'hA000_0000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] id;
    logic [3:0]  idx;
    logic [20:0] icon;
    logic [7:0]  urg;
    logic [31:0] hnd;
    logic        act;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [31:0] key;
    logic [20:0] icon;
    logic [7:0]  urgency;
    logic        urgent;
    logic [31:0] handle;
    logic        action;
    logic        fired;
    logic [4:0]  count;
    logic [31:0] revision;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [31:0] key_rid = '0;
  logic [31:0] entry_id = '0;
  logic [3:0]  entry_index = '0;
  logic [20:0] icon_code = '0;
  logic [7:0]  urgency_in = '0;
  logic [31:0] payload_handle = '0;
  logic        action_present = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_id;
  logic [31:0] result_key;
  logic [20:0] result_icon;
  logic [7:0]  result_urgency;
  logic        urgent_flag;
  logic [31:0] result_handle;
  logic        result_action;
  logic        action_fired;
  logic [4:0]  entry_count;
  logic [31:0] revision;

  // predicted table contents and counters
  entry_t      hist_table [CAPACITY];
  logic [4:0]  hist_fill = '0;
  logic [31:0] serial_ctr = '0;
  logic [31:0] revision_ctr = '0;

  outcome_t    expected_results [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  int          fault_count = 0;
  int          results_checked = 0;
  int          evicted_total = 0;
  int          fired_total = 0;
  int          op_seen [8] = '{default: 0};

  mru_keyed_history_table_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("mru_keyed_history_table_core verification failed");
    $finish;
  end

  function automatic int locate_id(input logic [31:0] id);
    int j;
    for (j = 0; j < hist_fill; j++)
      if (hist_table[j].id == id) return j;
    return -1;
  endfunction

  // drop the entry at pos and pull the older ones forward
  function automatic void close_gap(input int pos);
    int j;
    for (j = pos; j + 1 < hist_fill; j++)
      hist_table[j] = hist_table[j + 1];
    hist_fill--;
    revision_ctr++;
  endfunction

  task automatic predict_history(input request_t r, output outcome_t o);
    int  pos;
    int  j;
    logic hit;
    o   = '0;
    hit = 1'b0;
    pos = 0;
    case (r.op)
      OP_PUSH: begin
        if (r.key != '0)
          for (j = 0; j < hist_fill; j++)
            if (!hit && hist_table[j].key == r.key) begin
              hit = 1'b1;
              pos = j;
            end
        if (hit) begin
          o.id = hist_table[pos].id;
        end else begin
          if (hist_fill < CAPACITY) hist_fill++;
          else evicted_total++;
          pos = hist_fill - 1;
          serial_ctr++;
          o.id = serial_ctr;
        end
        for (j = pos; j > 0; j--)
          hist_table[j] = hist_table[j - 1];
        hist_table[0] = '{id: o.id, key: r.key, icon: r.icon, urgency: r.urg,
                          handle: r.hnd, action: r.act};
        revision_ctr++;
      end
      OP_DISMISS: begin
        pos = locate_id(r.id);
        if (pos < 0) o.status = ST_NOT_FOUND;
        else close_gap(pos);
      end
      OP_INVOKE: begin
        pos = locate_id(r.id);
        if (pos < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.key   = hist_table[pos].key;
          o.fired = (hist_table[pos].key != '0) && hist_table[pos].action;
          if (o.fired) fired_total++;
          close_gap(pos);
        end
      end
      OP_CLEAR: begin
        hist_fill = '0;
        revision_ctr++;
      end
      OP_BIND: begin
        if (hist_fill != '0 && hist_table[0].key == '0) hist_table[0].key = r.key;
      end
      OP_READ: begin
        if (r.idx < hist_fill) begin
          o.id      = hist_table[r.idx].id;
          o.key     = hist_table[r.idx].key;
          o.icon    = hist_table[r.idx].icon;
          o.urgency = hist_table[r.idx].urgency;
          o.urgent  = hist_table[r.idx].urgency >= URGENT_LEVEL;
          o.handle  = hist_table[r.idx].handle;
          o.action  = hist_table[r.idx].action;
        end else begin
          o.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    o.count    = hist_fill;
    o.revision = revision_ctr;
  endtask

  function automatic request_t make_req(input logic [2:0] op, input logic [31:0] key = '0,
                                        input logic [31:0] id = '0, input logic [3:0] idx = '0,
                                        input logic [20:0] icon = '0, input logic [7:0] urg = '0,
                                        input logic [31:0] hnd = '0, input logic act = 1'b0);
    request_t r;
    r = '{op: op, key: key, id: id, idx: idx, icon: icon, urg: urg, hnd: hnd, act: act};
    return r;
  endfunction

  // mostly well-formed traffic: keys from a small pool, ids and indexes taken from the table
  function automatic request_t random_request(input bit push_only);
    request_t r;
    int pick;
    int roll;
    r.key  = $urandom;
    r.id   = $urandom;
    r.idx  = 4'($urandom_range(0, 15));
    r.icon = 21'($urandom_range(0, ICON_MAX));
    r.urg  = 8'($urandom_range(0, 255));
    r.hnd  = $urandom;
    r.act  = 1'($urandom_range(0, 1));
    pick = push_only ? 0 : $urandom_range(0, 99);
    if (pick < 55)      r.op = OP_PUSH;
    else if (pick < 63) r.op = OP_DISMISS;
    else if (pick < 71) r.op = OP_INVOKE;
    else if (pick < 91) r.op = OP_READ;
    else if (pick < 96) r.op = OP_BIND;
    else if (pick < 97) r.op = OP_CLEAR;
    else                r.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    roll = $urandom_range(0, 19);
    if (roll < 8) r.key = '0;
    else if (roll < 17 && !push_only) r.key = KEY_POOL_BASE + $urandom_range(1, 6);
    if ((r.op == OP_DISMISS || r.op == OP_INVOKE) && hist_fill != '0 &&
        $urandom_range(0, 4) != 0)
      r.id = hist_table[$urandom_range(0, hist_fill - 1)].id;
    else if ($urandom_range(0, 1))
      r.id = serial_ctr - $urandom_range(0, 20);
    if (r.op == OP_READ && hist_fill != '0 && $urandom_range(0, 3) != 0)
      r.idx = 4'($urandom_range(0, hist_fill - 1));
    if ($urandom_range(0, 1)) r.urg = 8'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic send_request(input request_t r);
    outcome_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= r.op;
    key_rid        <= r.key;
    entry_id       <= r.id;
    entry_index    <= r.idx;
    icon_code      <= r.icon;
    urgency_in     <= r.urg;
    payload_handle <= r.hnd;
    action_present <= r.act;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_history(r, want);
    expected_results.push_back(want);
    op_seen[r.op]++;
  endtask

  function automatic void note_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on %s at %0t: expected %0h, got %0h", name, $time, want, got);
    end
  endfunction

  task automatic check_result();
    outcome_t want;
    if (expected_results.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) $display("result at %0t with no request waiting", $time);
      return;
    end
    want = expected_results.pop_front();
    note_field("status", 32'(want.status), 32'(status));
    note_field("result_id", want.id, result_id);
    note_field("result_key", want.key, result_key);
    note_field("result_icon", 32'(want.icon), 32'(result_icon));
    note_field("result_urgency", 32'(want.urgency), 32'(result_urgency));
    note_field("urgent_flag", 32'(want.urgent), 32'(urgent_flag));
    note_field("result_handle", want.handle, result_handle);
    note_field("result_action", 32'(want.action), 32'(result_action));
    note_field("action_fired", 32'(want.fired), 32'(action_fired));
    note_field("entry_count", 32'(want.count), 32'(entry_count));
    note_field("revision", want.revision, revision);
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) check_result();
    out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted down here
  always @(posedge clk)
    if (hold_left != 0) hold_left <= hold_left - 1;

  task automatic test_empty_table();
    send_request(make_req(OP_READ, '0, '0, 4'd0));
    send_request(make_req(OP_READ, '0, '0, 4'd15));
    send_request(make_req(OP_DISMISS, '0, 32'd0));
    send_request(make_req(OP_INVOKE, '0, 32'hFFFF_FFFF));
    send_request(make_req(OP_BIND, 32'hFFFF_FFFF));
    send_request(make_req(OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, ICON_MAX,
                          8'hFF, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(OP_SPARE_HI));
    send_request(make_req(OP_CLEAR));
  endtask

  task automatic test_push_and_replace();
    send_request(make_req(OP_PUSH, '0, '0, '0, ICON_MAX, 8'hFF, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(OP_PUSH, 32'hFFFF_FFFF, '0, '0, '0, 8'd0, '0, 1'b0));
    send_request(make_req(OP_PUSH, 32'd1, '0, '0, 21'h0F_0000, 8'd1, 32'h5A5A_A5A5, 1'b0));
    // same key again: moves from position 1 to the front, keeps its id
    send_request(make_req(OP_PUSH, 32'hFFFF_FFFF, '0, '0, 21'h00_1234, 8'd2, 32'd7, 1'b1));
    send_request(make_req(OP_READ, '0, '0, 4'd0));
    send_request(make_req(OP_READ, '0, '0, 4'd1));
    send_request(make_req(OP_READ, '0, '0, 4'd2));
    send_request(make_req(OP_READ, '0, '0, 4'd3));
  endtask

  task automatic test_bind_and_duplicates();
    send_request(make_req(OP_PUSH, '0, '0, '0, 21'd65, 8'd3, 32'd11, 1'b1));
    // bind a key already held further back, then push it: the front copy wins
    send_request(make_req(OP_BIND, 32'd1));
    send_request(make_req(OP_BIND, 32'd7));
    send_request(make_req(OP_PUSH, 32'd1, '0, '0, 21'd66, 8'd0, 32'd12, 1'b1));
    send_request(make_req(OP_READ, '0, '0, 4'd3));
  endtask

  task automatic test_remove_and_invoke();
    send_request(make_req(OP_INVOKE, '0, hist_table[0].id));
    send_request(make_req(OP_PUSH, 32'd5, '0, '0, 21'd1, 8'd9, 32'd13, 1'b0));
    send_request(make_req(OP_INVOKE, '0, hist_table[0].id));
    send_request(make_req(OP_PUSH, '0, '0, '0, 21'd2, 8'd9, 32'd14, 1'b1));
    send_request(make_req(OP_INVOKE, '0, hist_table[0].id));
    send_request(make_req(OP_DISMISS, '0, hist_table[hist_fill - 1].id));
    send_request(make_req(OP_DISMISS, '0, serial_ctr));
    send_request(make_req(OP_INVOKE, '0, 32'd0));
  endtask

  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
    int sent;
    int burst;
    int k;
    bit fill_mode;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < n_items) begin
      // fill bursts push the table past capacity so evictions happen
      fill_mode = $urandom_range(0, 9) < 3;
      burst = $urandom_range(10, 25);
      for (k = 0; k < burst && sent < n_items; k++) begin
        send_request(random_request(fill_mode));
        sent++;
      end
    end
  endtask

  task automatic test_receiver_backpressure();
    int k;
    send_idle_pct = 0;
    hold_left <= HOLD_CYCLES;
    for (k = 0; k < 20; k++) send_request(random_request(1'b0));
  endtask

  task automatic finish_run();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      fault_count += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end
    $display("covered %0d requests: push %0d, dismiss %0d, invoke %0d, clear %0d, bind %0d,",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3] + op_seen[4] + op_seen[5]
             + op_seen[6] + op_seen[7], op_seen[OP_PUSH], op_seen[OP_DISMISS],
             op_seen[OP_INVOKE], op_seen[OP_CLEAR], op_seen[OP_BIND]);
    $display("  read %0d, spare codes %0d; %0d results compared, %0d evictions, %0d fired",
             op_seen[OP_READ], op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI], results_checked,
             evicted_total, fired_total);
    if (fault_count == 0) begin
      $display("mru_keyed_history_table_core verification clean");
    end else begin
      $display("mru_keyed_history_table_core verification failed");
    end
    $finish;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 69;
    test_empty_table();
    test_push_and_replace();
    test_bind_and_duplicates();
    test_remove_and_invoke();
    test_random_traffic(240, 24, 69);
    test_receiver_backpressure();
    test_random_traffic(240, 69, 24);
    test_random_traffic(240, 0, 0);
    finish_run();
  end

endmodule
